@@ rtl/fls_pkg.sv @@
`default_nettype none
package fls_pkg;

	localparam int LUMA_BITS  = 24;
	localparam int COUNT_BITS = 24;
	localparam int SUM_BITS   = LUMA_BITS + COUNT_BITS;
	localparam int CHAN_BITS  = 8;
	localparam int WGT_BITS   = 16;

	localparam logic [LUMA_BITS-1:0]  LUMA_FULL = LUMA_BITS'(16711680);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// rec.709 weights, summing to 65536
	localparam logic [WGT_BITS-1:0] W_RED   = WGT_BITS'(13933);
	localparam logic [WGT_BITS-1:0] W_GREEN = WGT_BITS'(46871);
	localparam logic [WGT_BITS-1:0] W_BLUE  = WGT_BITS'(4732);

	localparam int MUL_STEPS = 3;
	localparam int DIV_STEPS = LUMA_BITS;
	localparam int STEP_BITS = $clog2(DIV_STEPS);

	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_MEAN  = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_RANGE = CFG_INDEX_BITS'(1);

	localparam logic [1:0] MUL_SEL_RED   = 2'd0;
	localparam logic [1:0] MUL_SEL_GREEN = 2'd1;
	localparam logic [1:0] MUL_SEL_BLUE  = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_UPD  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} fls_state_t;

endpackage
`default_nettype wire

@@ rtl/frame_luma_statistics.sv @@
`default_nettype none
// channel   direction  handshake              payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data (24 bit threshold)
// in        in         in_valid / in_ready    red, green, blue, last_pixel
// out       out        out_valid / out_ready  frame_mean, frame_min, frame_max, frame_spread,
//                                             pass, count_overflow
//
// a pixel goes through the transfer, 3 passes through the shared 8x16 multiplier
// and one update of sum, count, min and max
// the last pixel of a frame then runs the one-bit-per-step divider and loads the result
// register in ST_FIN, which waits while an earlier result is still unread
// cfg_ready is always high; thresholds reset to 0, frame state to its empty values
// the result register lets the next frame start while a result waits to be taken
module frame_luma_statistics
	import fls_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,

	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [LUMA_BITS-1:0]      cfg_data,

	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [CHAN_BITS-1:0]      red,
	input  wire logic [CHAN_BITS-1:0]      green,
	input  wire logic [CHAN_BITS-1:0]      blue,
	input  wire logic                      last_pixel,

	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [LUMA_BITS-1:0]           frame_mean,
	output logic [LUMA_BITS-1:0]           frame_min,
	output logic [LUMA_BITS-1:0]           frame_max,
	output logic [LUMA_BITS-1:0]           frame_spread,
	output logic                           pass,
	output logic                           count_overflow
);

	fls_state_t state_q;
	logic [STEP_BITS-1:0] step_q;
	logic out_valid_q;

	logic [LUMA_BITS-1:0] thr_mean_q;
	logic [LUMA_BITS-1:0] thr_range_q;

	logic [SUM_BITS-1:0]   sum_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [LUMA_BITS-1:0]  min_q;
	logic [LUMA_BITS-1:0]  max_q;
	logic                  ovf_q;

	logic [CHAN_BITS-1:0] red_q;
	logic [CHAN_BITS-1:0] green_q;
	logic [CHAN_BITS-1:0] blue_q;
	logic                 last_q;
	logic [LUMA_BITS-1:0] luma_q;
	logic [LUMA_BITS-1:0] range_q;

	logic [LUMA_BITS-1:0] mean_q;
	logic [LUMA_BITS-1:0] omin_q;
	logic [LUMA_BITS-1:0] omax_q;
	logic [LUMA_BITS-1:0] orange_q;
	logic                 pass_q;
	logic                 oovf_q;

	logic [CHAN_BITS-1:0]  mul_a;
	logic [WGT_BITS-1:0]   mul_b;
	logic [LUMA_BITS-1:0]  prod;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  trial_ge;
	logic [LUMA_BITS-1:0]  mean_val;
	logic                  fin_go;
	logic                  in_xfer;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign frame_mean     = mean_q;
	assign frame_min      = omin_q;
	assign frame_max      = omax_q;
	assign frame_spread   = orange_q;
	assign pass           = pass_q;
	assign count_overflow = oovf_q;

	// shared multiplier: one weighted channel per cycle
	always_comb begin
		unique case (step_q[1:0])
			MUL_SEL_RED: begin
				mul_a = red_q;
				mul_b = W_RED;
			end
			MUL_SEL_GREEN: begin
				mul_a = green_q;
				mul_b = W_GREEN;
			end
			MUL_SEL_BLUE: begin
				mul_a = blue_q;
				mul_b = W_BLUE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = {{(LUMA_BITS-CHAN_BITS){1'b0}}, mul_a} * {{(LUMA_BITS-WGT_BITS){1'b0}}, mul_b};

	// restoring division in place: upper part of sum_q is the remainder,
	// quotient bits shift in at the bottom
	assign trial    = sum_q[SUM_BITS-1:LUMA_BITS-1];
	assign diff     = trial - {1'b0, count_q};
	assign trial_ge = (trial >= {1'b0, count_q});
	assign mean_val = (count_q != '0) ? sum_q[LUMA_BITS-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_mean_q  <= '0;
			thr_range_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MIN_MEAN) begin
				thr_mean_q <= cfg_data;
			end else if (cfg_index == CFG_MIN_RANGE) begin
				thr_range_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			sum_q       <= '0;
			count_q     <= '0;
			min_q       <= LUMA_FULL;
			max_q       <= '0;
			ovf_q       <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_MUL;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					if (step_q == STEP_BITS'(MUL_STEPS-1)) begin
						state_q <= ST_UPD;
					end
					step_q <= step_q + STEP_BITS'(1);
				end
				ST_UPD: begin
					if (count_q == COUNT_MAX) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + COUNT_BITS'(1);
						sum_q   <= sum_q + {{COUNT_BITS{1'b0}}, luma_q};
					end
					if (luma_q < min_q) begin
						min_q <= luma_q;
					end
					if (luma_q > max_q) begin
						max_q <= luma_q;
					end
					step_q  <= '0;
					state_q <= last_q ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					sum_q <= {(trial_ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0]),
						sum_q[LUMA_BITS-2:0], trial_ge};
					if (step_q == STEP_BITS'(DIV_STEPS-1)) begin
						state_q <= ST_FIN;
					end
					step_q <= step_q + STEP_BITS'(1);
				end
				ST_FIN: begin
					if (fin_go) begin
						sum_q   <= '0;
						count_q <= '0;
						min_q   <= LUMA_FULL;
						max_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
			last_q  <= last_pixel;
			luma_q  <= '0;
		end else if (state_q == ST_MUL) begin
			luma_q <= luma_q + prod;
		end
		if (state_q == ST_DIV && step_q == '0) begin
			range_q <= (max_q >= min_q) ? max_q - min_q : '0;
		end
		if (fin_go) begin
			mean_q   <= mean_val;
			omin_q   <= min_q;
			omax_q   <= max_q;
			orange_q <= range_q;
			pass_q   <= (mean_val >= thr_mean_q) && (range_q >= thr_range_q);
			oovf_q   <= ovf_q;
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (count_q != '0))
		else $error("division started on an empty frame");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (sum_q[SUM_BITS-1:LUMA_BITS] < count_q))
		else $error("divider remainder not below the pixel count");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == COUNT_MAX))
		else $error("overflow flagged before the counter saturated");

	a_range_ok: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (frame_spread == frame_max - frame_min))
		else $error("range does not match max minus min");

	a_mean_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (frame_mean >= frame_min && frame_mean <= frame_max))
		else $error("mean outside min and max");

endmodule
`default_nettype wire

@@ tb/sv/frame_luma_statistics_tb.sv @@
`timescale 1ns / 100ps

module frame_luma_statistics_tb
	import fls_pkg::*;
();

	localparam int CLK_PERIOD    = 10;
	localparam int TIMEOUT_NS    = 5_000_000;
	localparam int RANDOM_PIXELS = 1100;
	localparam int SETTLE_CYCLES = 40;   // one pixel plus the divider, with margin
	localparam int HOLD_CYCLES   = 400;

	localparam int LUMA_WEIGHT_R = 13933;
	localparam int LUMA_WEIGHT_G = 46871;
	localparam int LUMA_WEIGHT_B = 4732;

	localparam logic [LUMA_BITS-1:0] THRESH_ALL_ONES = {LUMA_BITS{1'b1}};

	// indexes past the register list, which the block must ignore
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_2 = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_3 = CFG_INDEX_BITS'(3);

	typedef struct {
		logic [LUMA_BITS-1:0] frame_mean;
		logic [LUMA_BITS-1:0] frame_min;
		logic [LUMA_BITS-1:0] frame_max;
		logic [LUMA_BITS-1:0] frame_spread;
		logic                 pass;
		logic                 count_overflow;
	} frame_stats_t;

	class luma_stats_scoreboard;
		logic [LUMA_BITS-1:0]  min_mean;
		logic [LUMA_BITS-1:0]  min_range;
		logic [SUM_BITS-1:0]   luma_sum;
		logic [COUNT_BITS-1:0] px_count;
		logic [LUMA_BITS-1:0]  run_min;
		logic [LUMA_BITS-1:0]  run_max;
		logic                  overflow_seen;
		frame_stats_t          pending_frames[$];
		int errors;
		int pixels;
		int frames;
		int passes;
		int reg_writes;

		function new();
			min_mean   = '0;
			min_range  = '0;
			errors     = 0;
			pixels     = 0;
			frames     = 0;
			passes     = 0;
			reg_writes = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			luma_sum      = '0;
			px_count      = '0;
			run_min       = LUMA_FULL;
			run_max       = '0;
			overflow_seen = 1'b0;
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [LUMA_BITS-1:0] data);
			reg_writes++;
			case (idx)
				CFG_MIN_MEAN: begin
					min_mean = data;
				end
				CFG_MIN_RANGE: begin
					min_range = data;
				end
				default: begin
				end
			endcase
		endfunction

		function void note_pixel(logic [CHAN_BITS-1:0] r, logic [CHAN_BITS-1:0] g,
				logic [CHAN_BITS-1:0] b, logic last);
			logic [31:0]          luma32;
			logic [LUMA_BITS-1:0] luma;
			logic [SUM_BITS-1:0]  quotient;
			frame_stats_t         res;
			luma32 = r * LUMA_WEIGHT_R + g * LUMA_WEIGHT_G + b * LUMA_WEIGHT_B;
			luma   = luma32[LUMA_BITS-1:0];
			pixels++;
			// a saturated counter freezes the sum but min and max still move
			if (px_count == COUNT_MAX) begin
				overflow_seen = 1'b1;
			end else begin
				px_count++;
				luma_sum += SUM_BITS'(luma);
			end
			if (luma < run_min) begin
				run_min = luma;
			end
			if (luma > run_max) begin
				run_max = luma;
			end
			if (!last) begin
				return;
			end
			quotient = (px_count != 0) ? luma_sum / SUM_BITS'(px_count) : '0;
			res.frame_mean     = quotient[LUMA_BITS-1:0];
			res.frame_min      = run_min;
			res.frame_max      = run_max;
			res.frame_spread   = (run_max >= run_min) ? run_max - run_min : '0;
			res.pass           = (res.frame_mean >= min_mean) &&
				(res.frame_spread >= min_range);
			res.count_overflow = overflow_seen;
			pending_frames.push_back(res);
			clear_frame();
		endfunction

		function void compare_field(string field, logic [LUMA_BITS-1:0] want,
				logic [LUMA_BITS-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: frame %0d %s mismatch: expected %0d, got %0d",
					$time, frames, field, want, got);
			end
		endfunction

		function void check_frame(frame_stats_t got);
			frame_stats_t want;
			if (pending_frames.size() == 0) begin
				errors++;
				$display("%0t: result with no frame outstanding: expected none, got mean %0d",
					$time, got.frame_mean);
				return;
			end
			want = pending_frames.pop_front();
			compare_field("frame_mean", want.frame_mean, got.frame_mean);
			compare_field("frame_min", want.frame_min, got.frame_min);
			compare_field("frame_max", want.frame_max, got.frame_max);
			compare_field("frame_spread", want.frame_spread, got.frame_spread);
			compare_field("pass", LUMA_BITS'(want.pass), LUMA_BITS'(got.pass));
			compare_field("count_overflow", LUMA_BITS'(want.count_overflow),
				LUMA_BITS'(got.count_overflow));
			frames++;
			if (want.pass) begin
				passes++;
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [LUMA_BITS-1:0]      cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [CHAN_BITS-1:0]      red;
	logic [CHAN_BITS-1:0]      green;
	logic [CHAN_BITS-1:0]      blue;
	logic                      last_pixel;
	logic                      out_valid;
	logic                      out_ready;
	logic [LUMA_BITS-1:0]      frame_mean;
	logic [LUMA_BITS-1:0]      frame_min;
	logic [LUMA_BITS-1:0]      frame_max;
	logic [LUMA_BITS-1:0]      frame_spread;
	logic                      pass;
	logic                      count_overflow;

	bit no_in_gaps  = 1'b0;
	bit no_out_gaps = 1'b0;
	bit hold_output = 1'b0;

	luma_stats_scoreboard sb = new();

	frame_luma_statistics u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.last_pixel     (last_pixel),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_mean     (frame_mean),
		.frame_min      (frame_min),
		.frame_max      (frame_max),
		.frame_spread   (frame_spread),
		.pass           (pass),
		.count_overflow (count_overflow)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timed out with %0d frames outstanding",
			$time, sb.pending_frames.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// transfers are sampled at the edge, before any of this step's updates land
	always @(posedge clk) begin
		frame_stats_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.frame_mean     = frame_mean;
				got.frame_min      = frame_min;
				got.frame_max      = frame_max;
				got.frame_spread   = frame_spread;
				got.pass           = pass;
				got.count_overflow = count_overflow;
				sb.check_frame(got);
			end
			if (in_valid && in_ready) begin
				sb.note_pixel(red, green, blue, last_pixel);
			end
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
			end
		end
	end

	function automatic int idle_gap(bit steady);
		int roll;
		if (steady) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end
		if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CHAN_BITS-1:0] pick_channel();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			return '0;
		end
		if (roll == 1) begin
			return '1;
		end
		return CHAN_BITS'($urandom_range(0, 255));
	endfunction

	function automatic logic [LUMA_BITS-1:0] pick_threshold();
		int roll;
		roll = $urandom_range(0, 7);
		if (roll == 0) begin
			return '0;
		end
		if (roll == 1) begin
			return LUMA_FULL;
		end
		if (roll == 2) begin
			return THRESH_ALL_ONES;
		end
		return LUMA_BITS'($urandom_range(0, LUMA_FULL));
	endfunction

	// output side: bursts of ready with gaps, and a long hold when asked
	initial begin
		int burst;
		int gap;
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else begin
				burst = $urandom_range(1, 20);
				out_ready <= 1'b1;
				repeat (burst) @(posedge clk);
				gap = idle_gap(no_out_gaps);
				if (gap != 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	task automatic pause_input(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_pixel(logic [CHAN_BITS-1:0] r, logic [CHAN_BITS-1:0] g,
			logic [CHAN_BITS-1:0] b, logic last);
		int gap;
		in_valid   <= 1'b1;
		red        <= r;
		green      <= g;
		blue       <= b;
		last_pixel <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		gap = idle_gap(no_in_gaps);
		if (gap != 0) begin
			pause_input(gap);
		end
	endtask

	task automatic send_frame(int len, bit flat);
		logic [CHAN_BITS-1:0] r, g, b;
		int i;
		r = pick_channel();
		g = pick_channel();
		b = pick_channel();
		for (i = 0; i < len; i++) begin
			if (!flat && i != 0) begin
				r = pick_channel();
				g = pick_channel();
				b = pick_channel();
			end
			send_pixel(r, g, b, i == len - 1);
		end
	endtask

	task automatic write_threshold(logic [CFG_INDEX_BITS-1:0] idx, logic [LUMA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// registers only change once every frame result is out and the divider has gone quiet
	task automatic wait_drained();
		pause_input(1);
		while (sb.pending_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int phase_no;
		int nframes;
		int k;
		int len;
		int start_pixels;
		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_index  <= CFG_MIN_MEAN;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		red        <= '0;
		green      <= '0;
		blue       <= '0;
		last_pixel <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset thresholds: black, white, primaries, an uneven mean, alternating bits
		send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
		send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
		send_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
		send_pixel(8'h01, 8'h00, 8'h00, 1'b0);
		send_pixel(8'h00, 8'h00, 8'h01, 1'b0);
		send_pixel(8'h00, 8'h01, 8'h00, 1'b1);
		send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
		send_pixel(8'h55, 8'hAA, 8'h55, 1'b1);

		// mean threshold at full scale: only white gets through
		wait_drained();
		write_threshold(CFG_MIN_MEAN, LUMA_FULL);
		write_threshold(CFG_MIN_RANGE, '0);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_pixel(8'h00, 8'h00, 8'h00, 1'b1);

		// range threshold above full scale cannot be met, at full scale it just can
		wait_drained();
		write_threshold(CFG_MIN_MEAN, '0);
		write_threshold(CFG_MIN_RANGE, THRESH_ALL_ONES);
		send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
		wait_drained();
		write_threshold(CFG_MIN_RANGE, LUMA_FULL);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_pixel(8'h00, 8'h00, 8'h00, 1'b1);

		// writes past the register list must leave the thresholds alone
		wait_drained();
		write_threshold(CFG_SPARE_2, THRESH_ALL_ONES);
		write_threshold(CFG_SPARE_3, THRESH_ALL_ONES);
		send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

		start_pixels = sb.pixels;
		phase_no = 0;
		while (sb.pixels - start_pixels < RANDOM_PIXELS) begin
			phase_no++;
			wait_drained();
			write_threshold(CFG_MIN_MEAN, pick_threshold());
			write_threshold(CFG_MIN_RANGE, pick_threshold());
			if ($urandom_range(0, 3) == 0) begin
				write_threshold($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
					LUMA_BITS'($urandom()));
			end
			if (phase_no == 3) begin
				// short frames back to back into a stalled output, so the input backs up
				no_in_gaps  = 1'b1;
				hold_output = 1'b1;
				for (k = 0; k < 8; k++) begin
					send_frame($urandom_range(1, 3), 1'b0);
				end
			end else begin
				no_in_gaps  = (phase_no == 5);
				no_out_gaps = (phase_no == 5);
				nframes = $urandom_range(4, 12);
				for (k = 0; k < nframes; k++) begin
					len = $urandom_range(0, 99);
					if (len < 70) begin
						len = $urandom_range(1, 6);
					end else if (len < 95) begin
						len = $urandom_range(7, 24);
					end else begin
						len = $urandom_range(25, 80);
					end
					send_frame(len, $urandom_range(0, 7) == 0);
				end
			end
			no_in_gaps  = 1'b0;
			no_out_gaps = 1'b0;
		end

		wait_drained();
		$display("checked %0d frame results (%0d meeting both thresholds) from %0d pixels",
			sb.frames, sb.passes, sb.pixels);
		$display("%0d phases, %0d register writes, random stalls on both sides%s",
			phase_no, sb.reg_writes, " and one long output hold");
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
